/* sv/mtf_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mtf_pkg
// Shared types and constants of the mesh tangent frame accumulator.
// ----------------------------------------------------------------------------
package mtf_pkg;

    // Slot count; must be a power of two, indices wrap on the low bits.
    localparam int MAX_VERTICES = 4096;
    localparam int ADDR_W       = $clog2(MAX_VERTICES);
    localparam int IDX_W        = 12;

    localparam int VTX_W        = 80;   // pos x,y,z + tex u,v
    localparam int FRM_W        = 96;   // tangent x,y,z + bitangent x,y,z

    localparam int DIV_N_W      = 54;
    localparam int DIV_D_W      = 35;
    localparam int FACE_SAT     = 1073741823;
    localparam int UNIT_Q14     = 16384;

    localparam logic CMD_LOAD   = 1'b0;
    localparam logic CMD_TRI    = 1'b1;

    typedef struct packed {
        logic               cmd;
        logic [IDX_W-1:0]   load_index;
        logic signed [15:0] pos_x;
        logic signed [15:0] pos_y;
        logic signed [15:0] pos_z;
        logic signed [15:0] tex_u;
        logic signed [15:0] tex_v;
        logic [IDX_W-1:0]   corner_a;
        logic [IDX_W-1:0]   corner_b;
        logic [IDX_W-1:0]   corner_c;
    } t_in_req;

    typedef struct packed {
        logic [IDX_W-1:0]   vertex_id;
        logic signed [15:0] tangent_x;
        logic signed [15:0] tangent_y;
        logic signed [15:0] tangent_z;
        logic signed [15:0] bitangent_x;
        logic signed [15:0] bitangent_y;
        logic signed [15:0] bitangent_z;
        logic               degenerate;
        logic               last_corner;
    } t_out_rsp;

    typedef struct packed {
        logic               start;
        logic [DIV_N_W-1:0] dividend;
        logic [DIV_D_W-1:0] divisor;
    } t_div_req;

    typedef struct packed {
        logic               done;
        logic [DIV_N_W-1:0] quotient;
    } t_div_rsp;

endpackage

/* sv/mtf_if.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mtf_if
// Valid/ready channels of the accumulator: command input and frame output.
// ----------------------------------------------------------------------------
interface mtf_in_if import mtf_pkg::*; ();
    logic    valid;
    logic    ready;
    t_in_req data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface mtf_out_if import mtf_pkg::*; ();
    logic     valid;
    logic     ready;
    t_out_rsp data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

/* sv/mtf_ram.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mtf_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module mtf_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

/* sv/mtf_div.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mtf_div
// Restoring unsigned divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module mtf_div import mtf_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  t_div_req i_req,
    output t_div_rsp o_rsp
);
    localparam int CNT_W = $clog2(DIV_N_W);

    logic               r_busy;
    logic               r_done;
    logic [CNT_W-1:0]   r_cnt;
    logic [DIV_D_W-1:0] r_rem;
    logic [DIV_D_W-1:0] r_den;
    logic [DIV_N_W-1:0] r_quo;
    logic [DIV_D_W:0]   n_trial;
    logic               n_ge;
    logic [DIV_D_W:0]   n_diff;

    assign n_trial = {r_rem, r_quo[DIV_N_W-1]};
    assign n_ge    = n_trial >= {1'b0, r_den};
    assign n_diff  = n_trial - {1'b0, r_den};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
                r_rem  <= '0;
                r_den  <= i_req.divisor;
                r_quo  <= i_req.dividend;
            end else if (r_busy) begin
                r_rem <= n_ge ? n_diff[DIV_D_W-1:0] : n_trial[DIV_D_W-1:0];
                r_quo <= {r_quo[DIV_N_W-2:0], n_ge};
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == CNT_W'(DIV_N_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_rsp.done     = r_done;
    assign o_rsp.quotient = r_quo;
endmodule

/* sv/mtf_isqrt.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mtf_isqrt
// Integer square root of a 64-bit value, two radicand bits per cycle.
// ----------------------------------------------------------------------------
module mtf_isqrt (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic [63:0] i_val,
    output logic        o_done,
    output logic [31:0] o_root
);
    logic        r_busy;
    logic        r_done;
    logic [4:0]  r_cnt;
    logic [63:0] r_val;
    logic [33:0] r_rem;
    logic [31:0] r_root;
    logic [33:0] n_acc;
    logic [33:0] n_trial;
    logic        n_ge;

    assign n_acc   = {r_rem[31:0], r_val[63:62]};
    assign n_trial = {r_root, 2'b01};
    assign n_ge    = n_acc >= n_trial;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
                r_val  <= i_val;
                r_rem  <= '0;
                r_root <= '0;
            end else if (r_busy) begin
                r_val  <= {r_val[61:0], 2'b00};
                r_rem  <= n_ge ? n_acc - n_trial : n_acc;
                r_root <= {r_root[30:0], n_ge};
                r_cnt  <= r_cnt + 1'b1;
                if (r_cnt == 5'd31) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_root = r_root;
endmodule

/* sv/mesh_tangent_frame_accumulator_unit.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mesh_tangent_frame_accumulator_unit
// Per-triangle tangent/bitangent accumulation over a vertex and a frame RAM.
//
//   channel | dir | handshake       | payload
//   i_in    | in  | valid / ready   | t_in_req  (load vertex or triangle)
//   o_out   | out | valid / ready   | t_out_rsp (one per triangle corner)
//
// Load: written straight to the vertex RAM. Triangle time is set by the
// shared bit-serial divider (6 face divides, then 6 normalize divides per
// corner) and the square root, twice per corner; a degenerate triangle skips
// all of them, and a zero-length sum skips its root and divides.
// After reset all frame RAM slots are cleared, with i_in.ready low.
// A stalled output holds the next corner's write-back.
// ----------------------------------------------------------------------------
module mesh_tangent_frame_accumulator_unit import mtf_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    mtf_in_if.sink     i_in,
    mtf_out_if.source  o_out
);
    typedef enum logic [3:0] {
        S_CLEAR, S_IDLE, S_VRD, S_MUL, S_DET, S_FDIV, S_FWAIT, S_FRD, S_FCAP,
        S_SQ, S_SQRT, S_SWAIT, S_NDIV, S_NWAIT, S_OUT
    } t_state;

    t_state r_state;

    logic [ADDR_W-1:0]  r_addr;
    logic [ADDR_W-1:0]  r_idx [3];
    logic [1:0]         r_k;
    logic signed [15:0] r_pos [3][3];
    logic signed [15:0] r_tex [3][2];
    logic [3:0]         r_step;
    logic signed [33:0] r_prod;
    logic signed [33:0] r_first;
    logic signed [34:0] r_num [7];
    logic [2:0]         r_f;
    logic signed [30:0] r_face [6];
    logic               r_degen;
    logic signed [15:0] r_frm_b [3];
    logic signed [31:0] r_sum [3];
    logic               r_v;
    logic [1:0]         r_j;
    logic [61:0]        r_sqp;
    logic [63:0]        r_sq;
    logic [31:0]        r_len;
    logic signed [15:0] r_res [2][3];
    logic               r_out_valid;
    t_out_rsp           r_out;

    // memories
    logic               vtx_we;
    logic [ADDR_W-1:0]  vtx_raddr;
    logic [VTX_W-1:0]   vtx_rdata;
    logic               frm_we;
    logic [ADDR_W-1:0]  frm_waddr;
    logic [FRM_W-1:0]   frm_wdata;
    logic [FRM_W-1:0]   frm_rdata;

    logic signed [15:0] frm_t [3];
    logic signed [15:0] frm_b [3];

    logic signed [16:0] e1 [3];
    logic signed [16:0] e2 [3];
    logic signed [16:0] du1, dv1, du2, dv2;
    logic signed [16:0] mul_a, mul_b;
    logic signed [33:0] prod_w;
    logic [3:0]         prod_idx;
    logic [1:0]         mul_i;

    logic [2:0]         num_idx;
    logic [34:0]        num_mag, det_mag;
    logic [30:0]        face_sat;
    logic [30:0]        m [3];
    logic [30:0]        m_sel;
    logic [61:0]        sq_w;
    logic [14:0]        norm_q;

    t_div_req           div_req;
    t_div_rsp           div_rsp;
    logic               sqrt_start;
    logic               sqrt_done;
    logic [31:0]        sqrt_root;

    logic               in_fire;
    logic               out_free;

    function automatic logic [34:0] mag35(input logic [34:0] x);
        return x[34] ? 35'(-x) : x;
    endfunction

    assign in_fire  = i_in.valid && i_in.ready;
    assign out_free = !r_out_valid || o_out.ready;

    assign i_in.ready  = (r_state == S_IDLE);
    assign o_out.valid = r_out_valid;
    assign o_out.data  = r_out;

    // vertex store
    assign vtx_we = in_fire && (i_in.data.cmd == CMD_LOAD);

    always_comb begin
        vtx_raddr = i_in.data.corner_a[ADDR_W-1:0];
        if (r_state == S_VRD) begin
            case (r_k)
                2'd0:    vtx_raddr = r_idx[1];
                default: vtx_raddr = r_idx[2];
            endcase
        end
    end

    mtf_ram #(.WIDTH(VTX_W), .DEPTH(MAX_VERTICES)) u_vtx_ram (
        .i_clk   (i_clk),
        .i_we    (vtx_we),
        .i_waddr (i_in.data.load_index[ADDR_W-1:0]),
        .i_wdata ({i_in.data.pos_x, i_in.data.pos_y, i_in.data.pos_z,
                   i_in.data.tex_u, i_in.data.tex_v}),
        .i_raddr (vtx_raddr),
        .o_rdata (vtx_rdata)
    );

    // frame store
    assign frm_we    = (r_state == S_CLEAR) ||
                       ((r_state == S_OUT) && out_free && !r_degen);
    assign frm_waddr = (r_state == S_CLEAR) ? r_addr : r_idx[r_k];
    assign frm_wdata = (r_state == S_CLEAR) ? '0 :
                       {r_res[0][0], r_res[0][1], r_res[0][2],
                        r_res[1][0], r_res[1][1], r_res[1][2]};

    mtf_ram #(.WIDTH(FRM_W), .DEPTH(MAX_VERTICES)) u_frm_ram (
        .i_clk   (i_clk),
        .i_we    (frm_we),
        .i_waddr (frm_waddr),
        .i_wdata (frm_wdata),
        .i_raddr (r_idx[r_k]),
        .o_rdata (frm_rdata)
    );

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            frm_t[i] = frm_rdata[FRM_W-1-16*i -: 16];
            frm_b[i] = frm_rdata[FRM_W/2-1-16*i -: 16];
        end
    end

    // edges and deltas
    always_comb begin
        for (int i = 0; i < 3; i++) begin
            e1[i] = {r_pos[1][i][15], r_pos[1][i]} - {r_pos[0][i][15], r_pos[0][i]};
            e2[i] = {r_pos[2][i][15], r_pos[2][i]} - {r_pos[0][i][15], r_pos[0][i]};
        end
        du1 = {r_tex[1][0][15], r_tex[1][0]} - {r_tex[0][0][15], r_tex[0][0]};
        dv1 = {r_tex[1][1][15], r_tex[1][1]} - {r_tex[0][1][15], r_tex[0][1]};
        du2 = {r_tex[2][0][15], r_tex[2][0]} - {r_tex[0][0][15], r_tex[0][0]};
        dv2 = {r_tex[2][1][15], r_tex[2][1]} - {r_tex[0][1][15], r_tex[0][1]};
    end

    // product pairs: det, tangent numerators, bitangent numerators
    always_comb begin
        mul_a = du1;
        mul_b = dv2;
        mul_i = 2'd0;
        case (r_step[3:1])
            3'd0: begin
                mul_a = r_step[0] ? du2 : du1;
                mul_b = r_step[0] ? dv1 : dv2;
            end
            3'd1, 3'd2, 3'd3: begin
                mul_i = 2'(r_step[3:1] - 3'd1);
                mul_a = r_step[0] ? dv1 : dv2;
                mul_b = r_step[0] ? e2[mul_i] : e1[mul_i];
            end
            3'd4, 3'd5, 3'd6: begin
                mul_i = 2'(r_step[3:1] - 3'd4);
                mul_a = r_step[0] ? du2 : du1;
                mul_b = r_step[0] ? e1[mul_i] : e2[mul_i];
            end
            default: begin
                mul_a = du1;
                mul_b = dv2;
            end
        endcase
    end

    assign prod_w   = mul_a * mul_b;
    assign prod_idx = r_step - 4'd1;

    // face divide operands
    assign num_idx  = r_f + 3'd1;
    assign num_mag  = mag35(r_num[num_idx]);
    assign det_mag  = mag35(r_num[0]);
    assign face_sat = (div_rsp.quotient > DIV_N_W'(FACE_SAT)) ? 31'(FACE_SAT)
                                                              : div_rsp.quotient[30:0];

    // normalize operands
    always_comb begin
        for (int i = 0; i < 3; i++) begin
            m[i] = r_sum[i][31] ? 31'(-r_sum[i]) : r_sum[i][30:0];
        end
        case (r_j)
            2'd0:    m_sel = m[0];
            2'd1:    m_sel = m[1];
            default: m_sel = m[2];
        endcase
    end

    assign sq_w   = m_sel * m_sel;
    assign norm_q = (div_rsp.quotient > DIV_N_W'(UNIT_Q14)) ? 15'(UNIT_Q14)
                                                            : div_rsp.quotient[14:0];

    always_comb begin
        div_req.start    = 1'b0;
        div_req.dividend = {1'b0, num_mag, 18'b0} + {20'b0, det_mag[34:1]};
        div_req.divisor  = det_mag;
        case (r_state)
            S_FDIV: div_req.start = 1'b1;
            S_NDIV: begin
                div_req.start    = 1'b1;
                div_req.dividend = {9'b0, m_sel, 14'b0} + {23'b0, r_len[31:1]};
                div_req.divisor  = {3'b0, r_len};
            end
            default: div_req.start = 1'b0;
        endcase
    end

    mtf_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (div_req),
        .o_rsp   (div_rsp)
    );

    assign sqrt_start = (r_state == S_SQRT) && (r_sq != '0);

    mtf_isqrt u_isqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (sqrt_start),
        .i_val   (r_sq),
        .o_done  (sqrt_done),
        .o_root  (sqrt_root)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_addr      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (o_out.valid && o_out.ready) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_CLEAR: begin
                    r_addr <= r_addr + 1'b1;
                    if (r_addr == ADDR_W'(MAX_VERTICES - 1)) begin
                        r_state <= S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (in_fire && (i_in.data.cmd == CMD_TRI)) begin
                        r_idx[0] <= i_in.data.corner_a[ADDR_W-1:0];
                        r_idx[1] <= i_in.data.corner_b[ADDR_W-1:0];
                        r_idx[2] <= i_in.data.corner_c[ADDR_W-1:0];
                        r_k      <= 2'd0;
                        r_state  <= S_VRD;
                    end
                end
                S_VRD: begin
                    r_pos[r_k][0] <= vtx_rdata[79:64];
                    r_pos[r_k][1] <= vtx_rdata[63:48];
                    r_pos[r_k][2] <= vtx_rdata[47:32];
                    r_tex[r_k][0] <= vtx_rdata[31:16];
                    r_tex[r_k][1] <= vtx_rdata[15:0];
                    if (r_k == 2'd2) begin
                        r_step  <= '0;
                        r_state <= S_MUL;
                    end else begin
                        r_k <= r_k + 2'd1;
                    end
                end
                S_MUL: begin
                    r_prod <= prod_w;
                    if (r_step != 4'd0) begin
                        if (!prod_idx[0]) begin
                            r_first <= r_prod;
                        end else begin
                            r_num[prod_idx[3:1]] <= {r_first[33], r_first}
                                                  - {r_prod[33], r_prod};
                        end
                    end
                    r_step <= r_step + 4'd1;
                    if (r_step == 4'd14) begin
                        r_state <= S_DET;
                    end
                end
                S_DET: begin
                    r_k <= 2'd0;
                    r_f <= 3'd0;
                    if (r_num[0] == '0) begin
                        r_degen <= 1'b1;
                        r_state <= S_FRD;
                    end else begin
                        r_degen <= 1'b0;
                        r_state <= S_FDIV;
                    end
                end
                S_FDIV: r_state <= S_FWAIT;
                S_FWAIT: begin
                    if (div_rsp.done) begin
                        r_face[r_f] <= (r_num[num_idx][34] ^ r_num[0][34]) ? -face_sat
                                                                           : face_sat;
                        if (r_f == 3'd5) begin
                            r_state <= S_FRD;
                        end else begin
                            r_f     <= r_f + 3'd1;
                            r_state <= S_FDIV;
                        end
                    end
                end
                S_FRD: r_state <= S_FCAP;
                S_FCAP: begin
                    for (int i = 0; i < 3; i++) begin
                        r_frm_b[i]  <= frm_b[i];
                        r_res[0][i] <= frm_t[i];
                        r_res[1][i] <= frm_b[i];
                        r_sum[i]    <= {{16{frm_t[i][15]}}, frm_t[i]}
                                     + {r_face[i][30], r_face[i]};
                    end
                    r_v <= 1'b0;
                    r_j <= 2'd0;
                    r_state <= r_degen ? S_OUT : S_SQ;
                end
                S_SQ: begin
                    r_sqp <= sq_w;
                    r_sq  <= (r_j == 2'd0) ? '0 : r_sq + {2'b0, r_sqp};
                    r_j   <= r_j + 2'd1;
                    if (r_j == 2'd3) begin
                        r_state <= S_SQRT;
                    end
                end
                S_SQRT: begin
                    r_j <= 2'd0;
                    if (r_sq == '0) begin
                        for (int i = 0; i < 3; i++) begin
                            r_res[r_v][i] <= '0;
                        end
                        if (!r_v) begin
                            r_v <= 1'b1;
                            for (int i = 0; i < 3; i++) begin
                                r_sum[i] <= {{16{r_frm_b[i][15]}}, r_frm_b[i]}
                                          + {r_face[3+i][30], r_face[3+i]};
                            end
                            r_state <= S_SQ;
                        end else begin
                            r_state <= S_OUT;
                        end
                    end else begin
                        r_state <= S_SWAIT;
                    end
                end
                S_SWAIT: begin
                    if (sqrt_done) begin
                        r_len   <= sqrt_root;
                        r_state <= S_NDIV;
                    end
                end
                S_NDIV: r_state <= S_NWAIT;
                S_NWAIT: begin
                    if (div_rsp.done) begin
                        r_res[r_v][r_j] <= r_sum[r_j][31] ? -{1'b0, norm_q}
                                                          : {1'b0, norm_q};
                        if (r_j == 2'd2) begin
                            r_j <= 2'd0;
                            if (!r_v) begin
                                r_v <= 1'b1;
                                for (int i = 0; i < 3; i++) begin
                                    r_sum[i] <= {{16{r_frm_b[i][15]}}, r_frm_b[i]}
                                              + {r_face[3+i][30], r_face[3+i]};
                                end
                                r_state <= S_SQ;
                            end else begin
                                r_state <= S_OUT;
                            end
                        end else begin
                            r_j     <= r_j + 2'd1;
                            r_state <= S_NDIV;
                        end
                    end
                end
                S_OUT: begin
                    if (out_free) begin
                        r_out_valid       <= 1'b1;
                        r_out.vertex_id   <= IDX_W'(r_idx[r_k]);
                        r_out.tangent_x   <= r_res[0][0];
                        r_out.tangent_y   <= r_res[0][1];
                        r_out.tangent_z   <= r_res[0][2];
                        r_out.bitangent_x <= r_res[1][0];
                        r_out.bitangent_y <= r_res[1][1];
                        r_out.bitangent_z <= r_res[1][2];
                        r_out.degenerate  <= r_degen;
                        r_out.last_corner <= (r_k == 2'd2);
                        if (r_k == 2'd2) begin
                            r_state <= S_IDLE;
                        end else begin
                            r_k     <= r_k + 2'd1;
                            r_state <= S_FRD;
                        end
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end
endmodule
